// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== rtl/gbwl_pkg.sv =====
`default_nettype none

package gbwl_pkg;

  // Grid size; node index widths and the memory depth follow from it.
  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 32;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int DEPTH     = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LAST_ROW  = GRID_ROWS - 2;
  localparam int LAST_COL  = GRID_COLS - 2;

  // Input item layout in s_tdata, lowest bit first.
  localparam int ROW_LSB     = 0;
  localparam int COL_LSB     = 5;
  localparam int VX_LSB      = 10;
  localparam int VY_LSB      = 26;
  localparam int QX_LSB      = 42;
  localparam int QY_LSB      = 74;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 32;

  // Q1.16 weight of a whole cell.
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  localparam logic [31:0] ORIGIN_RESET = 32'h0000_0000;
  localparam logic [31:0] SCALE_RESET  = 32'h0001_0000;

  typedef enum logic {
    CMD_WRITE_NODE = 1'b0,
    CMD_QUERY      = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_SCALE_X  = 2'd2,
    CFG_SCALE_Y  = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOC,
    ST_READ,
    ST_CAPT,
    ST_BLEND1,
    ST_BLEND2,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       write_node;
    logic       load_query;
    logic       mul_en;
    logic       loc_en;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       blend1_en;
    logic       blend2_en;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/gbwl_ctrl.sv =====
`default_nettype none

module gbwl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic          s_tuser,
  input  wire gbwl_pkg::sts_t sts,
  output gbwl_pkg::cmd_t     cmd
);
  import gbwl_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       accept;

  assign accept = s_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && (command_t'(s_tuser) == CMD_QUERY)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:    state_next = ST_LOC;
      ST_LOC:    state_next = ST_READ;
      ST_READ: begin
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = ST_CAPT;
        end
      end
      ST_CAPT:   state_next = ST_BLEND1;
      ST_BLEND1: state_next = ST_BLEND2;
      ST_BLEND2: state_next = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.write_node = accept && (command_t'(s_tuser) == CMD_WRITE_NODE);
        cmd.load_query = accept && (command_t'(s_tuser) == CMD_QUERY);
      end
      ST_MUL:    cmd.mul_en = 1'b1;
      ST_LOC:    cmd.loc_en = 1'b1;
      ST_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = cnt;
        cmd.cap_en  = (cnt != 2'd0);
        cmd.cap_sel = cnt - 2'd1;
      end
      ST_CAPT: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd3;
      end
      ST_BLEND1: cmd.blend1_en = 1'b1;
      ST_BLEND2: cmd.blend2_en = 1'b1;
      ST_FINISH: cmd.out_load = sts.out_free;
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

`include "assert_macros.svh"

  // Every node read is captured on the following cycle.
  `ASSERT_CLK(a_read_then_capture, cmd.rd_en |=> cmd.cap_en, "read data not captured")
  // A result is only loaded into a free output register.
  `ASSERT_CLK(a_load_when_free, cmd.out_load |-> sts.out_free, "output overwritten")

endmodule

`default_nettype wire

// ===== rtl/gbwl_datapath.sv =====
`default_nettype none

module gbwl_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [31:0]                         cfg_wdata,
  input  wire logic [gbwl_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  wire gbwl_pkg::cmd_t                      cmd,
  output gbwl_pkg::sts_t                           sts,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [gbwl_pkg::OUT_TDATA_W-1:0]         m_tdata
);
  import gbwl_pkg::*;

  // Configuration registers.
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic [31:0]        scale_x;
  logic [31:0]        scale_y;

  // Input fields.
  logic [4:0]         in_row;
  logic [4:0]         in_col;
  logic [15:0]        in_vel_x;
  logic [15:0]        in_vel_y;
  logic signed [31:0] in_qx;
  logic signed [31:0] in_qy;

  // Node memories.
  logic [15:0]        mem_x [DEPTH];
  logic [15:0]        mem_y [DEPTH];
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_ok;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ROW_W-1:0]   rd_row;
  logic [COL_W-1:0]   rd_col;
  logic [15:0]        rd_x;
  logic [15:0]        rd_y;

  // Location pipeline.
  logic signed [32:0] dist_x;
  logic signed [32:0] dist_y;
  logic               pos_x;
  logic               pos_y;
  logic [63:0]        prod_x;
  logic [63:0]        prod_y;
  logic [ROW_W-1:0]   cell_x;
  logic [COL_W-1:0]   cell_y;
  logic [16:0]        lam;
  logic [16:0]        mu;

  // Blend pipeline.
  logic signed [15:0] node_x [4];
  logic signed [15:0] node_y [4];
  logic signed [31:0] near_x;
  logic signed [31:0] far_x;
  logic signed [31:0] near_y;
  logic signed [31:0] far_y;
  logic signed [49:0] prod2_x;
  logic signed [49:0] prod2_y;
  logic signed [49:0] sum_x;
  logic signed [49:0] sum_y;
  logic [15:0]        res_x;
  logic [15:0]        res_y;
  logic               out_valid;

  assign in_row   = s_tdata[ROW_LSB +: 5];
  assign in_col   = s_tdata[COL_LSB +: 5];
  assign in_vel_x = s_tdata[VX_LSB +: 16];
  assign in_vel_y = s_tdata[VY_LSB +: 16];
  assign in_qx    = $signed(s_tdata[QX_LSB +: 32]);
  assign in_qy    = $signed(s_tdata[QY_LSB +: 32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= ORIGIN_RESET;
      origin_y <= ORIGIN_RESET;
      scale_x  <= SCALE_RESET;
      scale_y  <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ORIGIN_X: origin_x <= cfg_wdata;
        CFG_ORIGIN_Y: origin_y <= cfg_wdata;
        CFG_SCALE_X:  scale_x  <= cfg_wdata;
        CFG_SCALE_Y:  scale_y  <= cfg_wdata;
        default:      origin_x <= origin_x;
      endcase
    end
  end

  // Node writes outside the grid are dropped.
  assign wr_ok   = (int'(in_row) < GRID_ROWS) && (int'(in_col) < GRID_COLS);
  assign wr_addr = ADDR_W'(int'(in_row) * GRID_COLS + int'(in_col));

  // Read order: (i,j), (i+1,j), (i,j+1), (i+1,j+1).
  assign rd_row  = cell_x + ROW_W'(cmd.rd_sel[0]);
  assign rd_col  = cell_y + COL_W'(cmd.rd_sel[1]);
  assign rd_addr = ADDR_W'(int'(rd_row) * GRID_COLS + int'(rd_col));

  always_ff @(posedge clk) begin
    if (cmd.write_node && wr_ok) begin
      mem_x[wr_addr] <= in_vel_x;
      mem_y[wr_addr] <= in_vel_y;
    end
    if (cmd.rd_en) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      dist_x <= 33'(in_qx) - 33'(origin_x);
      dist_y <= 33'(in_qy) - 33'(origin_y);
    end
    if (cmd.mul_en) begin
      pos_x  <= !dist_x[32] && (dist_x[31:0] != 32'd0);
      pos_y  <= !dist_y[32] && (dist_y[31:0] != 32'd0);
      prod_x <= 64'(dist_x[31:0]) * 64'(scale_x);
      prod_y <= 64'(dist_y[31:0]) * 64'(scale_y);
    end
    if (cmd.loc_en) begin
      if (!pos_x) begin
        cell_x <= '0;
        lam    <= '0;
      end else if (prod_x[63:32] > 32'(LAST_ROW)) begin
        cell_x <= ROW_W'(LAST_ROW);
        lam    <= FRAC_ONE;
      end else begin
        cell_x <= prod_x[32 +: ROW_W];
        lam    <= {1'b0, prod_x[31:16]};
      end
      if (!pos_y) begin
        cell_y <= '0;
        mu     <= '0;
      end else if (prod_y[63:32] > 32'(LAST_COL)) begin
        cell_y <= COL_W'(LAST_COL);
        mu     <= FRAC_ONE;
      end else begin
        cell_y <= prod_y[32 +: COL_W];
        mu     <= {1'b0, prod_y[31:16]};
      end
    end
  end

  // Blend helper: a + l*(b-a) in Q.16, exact for Q8.8 nodes.
  function automatic logic signed [31:0] lerp16(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic [16:0]        w);
    logic signed [34:0] diff;
    logic signed [34:0] wt;
    logic signed [34:0] acc;
    diff = 35'(b) - 35'(a);
    wt   = $signed(35'(w));
    acc  = (35'(a) <<< 16) + wt * diff;
    return acc[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      node_x[cmd.cap_sel] <= rd_x;
      node_y[cmd.cap_sel] <= rd_y;
    end
    if (cmd.blend1_en) begin
      near_x <= lerp16(node_x[0], node_x[1], lam);
      far_x  <= lerp16(node_x[2], node_x[3], lam);
      near_y <= lerp16(node_y[0], node_y[1], lam);
      far_y  <= lerp16(node_y[2], node_y[3], lam);
    end
    if (cmd.blend2_en) begin
      prod2_x <= $signed(50'(mu)) * (50'(far_x) - 50'(near_x));
      prod2_y <= $signed(50'(mu)) * (50'(far_y) - 50'(near_y));
    end
  end

  // Dropping the low 32 bits of the sum floors toward minus infinity.
  assign sum_x = (50'(near_x) <<< 16) + prod2_x;
  assign sum_y = (50'(near_y) <<< 16) + prod2_y;

  always_comb begin
    res_x = sum_x[47:32];
    res_y = sum_y[47:32];
    if ((res_x == 16'd0) && (res_y == 16'd0)) begin
      res_x = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {res_y, res_x};
    end
  end

  assign m_tvalid     = out_valid;
  assign sts.out_free = !out_valid || m_tready;

`include "assert_macros.svh"

  // The zero guard means a result is never all zeros.
  `ASSERT_NEVER(a_no_zero_result, m_tvalid && (m_tdata == 32'd0), "zero guard failed")

endmodule

`default_nettype wire

// ===== rtl/grid_bilinear_wind_lookup_unit.sv =====
// A query passes through MUL, LOC, READ, CAPT, BLEND1, BLEND2 and FINISH, which
// loads its result into the output register. A node write is done in IDLE. The
// four neighbor reads use the single read port of each node memory, one per
// cycle. Items are taken only in IDLE; a stalled output holds a query in FINISH.
// Reset (rst, synchronous) clears the controller, the output valid and the
// configuration registers; the node memories are not cleared.
`default_nettype none

module grid_bilinear_wind_lookup_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port: index 0 origin_x, 1 origin_y,
  // 2 cells_per_unit_x, 3 cells_per_unit_y.
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [31:0]                         cfg_wdata,
  // Input items.
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // s_tdata: node_row[4:0], node_col[9:5], node_vel_x[25:10], node_vel_y[41:26],
  // query_x[73:42], query_y[105:74], zero fill [111:106].
  input  wire logic [gbwl_pkg::IN_TDATA_W-1:0]     s_tdata,
  // s_tuser: command[0] (0 writes a node, 1 queries).
  input  wire logic                                s_tuser,
  // Result items.
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // m_tdata: wind_x[15:0], wind_y[31:16].
  output logic [gbwl_pkg::OUT_TDATA_W-1:0]         m_tdata
);
  import gbwl_pkg::*;

  // The controller sequences a query through scaling, cell location, four
  // node reads, two blend steps and the output load. A node write is done
  // in the accepting cycle. The output register lets the next item be
  // accepted while a result waits for m_tready.
  cmd_t cmd;
  sts_t sts;

  gbwl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the two node memories, the
  // 32x32 position scaling multipliers and the bilinear blend.
  gbwl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
